// ----- sv/cnv_pkg.sv -----
// Shared constants, types and helper functions of the 3x3 convolution core.
package cnv_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int COEF_BITS  = 8;
	localparam int KDIM       = 3;
	localparam int TAPS       = KDIM * KDIM;
	localparam int PIX_W      = 8;
	localparam int PIX_MAX    = 255;
	localparam int MAX_HEIGHT = 4096;

	// register field widths
	localparam int WREG_W     = 10;
	localparam int HREG_W     = 13;
	localparam int MASK_W     = 3 * COEF_BITS;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = (MASK_W > HREG_W) ? MASK_W : HREG_W;

	// largest usable row length: bounded by the store and by the register field
	localparam int WMAX_INT   = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int COL_W      = $clog2(WMAX_INT);
	localparam int OROW_W     = $clog2(MAX_HEIGHT);

	// datapath widths
	localparam int PROD_W     = PIX_W + COEF_BITS + 1;
	localparam int SUM_W      = PROD_W + 4;

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic [MASK_W-1:0] mask_t;
	typedef logic signed [COEF_BITS-1:0] coef_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MASK_TOP = 3'd0,
		REG_MASK_MID = 3'd1,
		REG_MASK_BOT = 3'd2,
		REG_PAD_MODE = 3'd3,
		REG_WIDTH    = 3'd4,
		REG_HEIGHT   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             frame_last;
	} res_t;

	function automatic mask_t mask_pack(input int a, input int b, input int c);
		return {COEF_BITS'(a), COEF_BITS'(b), COEF_BITS'(c)};
	endfunction

	// left coefficient sits in the highest field
	function automatic coef_t coef_at(input mask_t row, input int k);
		return coef_t'(row[(2 - k) * COEF_BITS +: COEF_BITS]);
	endfunction

	localparam mask_t MASK_TOP_RST = mask_pack(0, -1, 0);
	localparam mask_t MASK_MID_RST = mask_pack(-1, 4, -1);
	localparam mask_t MASK_BOT_RST = mask_pack(0, -1, 0);

endpackage

// ----- sv/cnv_stream_if.sv -----
// Valid/ready stream interfaces for pixel items and result items.
interface cnv_in_if;
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic [cnv_pkg::PIX_W-1:0] pixel_in;

	modport source(output valid, output command, output pixel_in, input ready);
	modport sink(input valid, input command, input pixel_in, output ready);
endinterface

interface cnv_out_if;
	logic                      valid;
	logic                      ready;
	logic [cnv_pkg::PIX_W-1:0] pixel_out;
	logic                      frame_last;

	modport source(output valid, output pixel_out, output frame_last, input ready);
	modport sink(input valid, input pixel_out, input frame_last, output ready);
endinterface

// ----- sv/conv3x3_padded_clamp_core.sv -----
// Streaming 3x3 convolution core with zero or replicate border padding and 0..255 clamp.
//
// Pixels enter in raster order, one item per clock. Each item reads one column of
// the two line stores (synchronous memories) and writes it back the next
// cycle, so a new item can follow every clock; a back-to-back hit on the same column
// (one-pixel rows) is covered by a write-to-read forward. The result of an item passes
// the pipeline stages and then leaves a small result queue; the stream keeps its
// one-item-per-clock rate as long as the sink takes results, and input ready drops
// only when eight results are in flight or queued and not yet taken. Results lag
// their pixels by one row plus one pixel: after the last pixel of a frame, send
// drain items (command 1) to flush the last row plus one pixel; frame_last marks the
// final result, after which a new frame starts. A drain sent before the frame is
// complete is taken and dropped. Writing image_width or image_height restarts the
// frame. The line stores need no clearing pass after reset: entries that were never
// written only feed border taps, which are always padded.
module conv3x3_padded_clamp_core (
	input  logic                                clk,
	input  logic                                arst_n,
	cnv_in_if.sink                              in_stream,
	cnv_out_if.source                           out_stream,
	input  logic                                wr_en,
	input  logic [cnv_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [cnv_pkg::CFG_DATA_W-1:0]      wr_data
);

	localparam int TAPS = cnv_pkg::TAPS;
	localparam int PW   = cnv_pkg::PIX_W;

	// configuration registers
	cnv_pkg::mask_t                  mask_top_q, mask_mid_q, mask_bot_q;
	logic                            pad_mode_q;
	logic [cnv_pkg::WREG_W-1:0]      width_q;
	logic [cnv_pkg::HREG_W-1:0]      height_q;

	logic [cnv_pkg::WREG_W-1:0]      eff_w;
	logic [cnv_pkg::HREG_W-1:0]      eff_h;
	logic                            restart;

	// position counters
	logic [cnv_pkg::HREG_W-1:0]      in_row_q;
	logic [cnv_pkg::COL_W-1:0]       in_col_q;
	logic [cnv_pkg::OROW_W-1:0]      out_row_q;
	logic [cnv_pkg::COL_W-1:0]       out_col_q;

	// accept stage
	logic                            acc, is_pixel, drop, step, emit, last;
	logic                            rv_top, rv_bot, cv_left, cv_right;
	logic [cnv_pkg::WREG_W-1:0]      in_col_inc, out_col_inc;
	logic [cnv_pkg::ADDR_W-1:0]      rd_addr;
	logic [cnv_pkg::FIFO_AW:0]       pending_q;

	// line stores
	logic [PW-1:0]                   upper_mem [cnv_pkg::MAX_WIDTH];
	logic [PW-1:0]                   lower_mem [cnv_pkg::MAX_WIDTH];
	logic [PW-1:0]                   up_rd_q, lo_rd_q;
	logic                            fwd_q;
	logic [PW-1:0]                   fwd_up_q, fwd_lo_q;

	// stage 1: memory data and window update
	logic                            v_s1, isp_s1, emit_s1, last_s1;
	logic                            rv_top_s1, rv_bot_s1, cv_left_s1, cv_right_s1;
	logic [PW-1:0]                   pix_s1;
	logic [cnv_pkg::ADDR_W-1:0]      addr_s1;
	logic [PW-1:0]                   up_now, lo_now;
	logic [PW-1:0]                   win_q    [TAPS];
	logic [PW-1:0]                   win_next [TAPS];
	logic [PW-1:0]                   tap_sel  [TAPS];

	// stages 2 to 4: taps, products, row sums
	logic                            v_s2, v_s3, v_s4;
	logic                            last_s2, last_s3, last_s4;
	logic [PW-1:0]                   tap_s2  [TAPS];
	logic signed [cnv_pkg::PROD_W-1:0] prod_s3 [TAPS];
	logic signed [cnv_pkg::SUM_W-1:0]  rsum_s4 [cnv_pkg::KDIM];
	cnv_pkg::coef_t                  coef_c  [TAPS];
	logic signed [cnv_pkg::SUM_W-1:0]  total;
	logic [PW-1:0]                   clamped;

	// result queue
	cnv_pkg::res_t                   fifo_q [cnv_pkg::FIFO_DEPTH];
	logic [cnv_pkg::FIFO_AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [cnv_pkg::FIFO_AW:0]       cnt_q;
	logic                            push, pop;

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_top_q <= cnv_pkg::MASK_TOP_RST;
			mask_mid_q <= cnv_pkg::MASK_MID_RST;
			mask_bot_q <= cnv_pkg::MASK_BOT_RST;
			pad_mode_q <= 1'b0;
			width_q    <= cnv_pkg::WREG_W'(512);
			height_q   <= cnv_pkg::HREG_W'(512);
		end else if (wr_en) begin
			unique case (cnv_pkg::cfg_reg_t'(wr_index))
				cnv_pkg::REG_MASK_TOP: mask_top_q <= wr_data[cnv_pkg::MASK_W-1:0];
				cnv_pkg::REG_MASK_MID: mask_mid_q <= wr_data[cnv_pkg::MASK_W-1:0];
				cnv_pkg::REG_MASK_BOT: mask_bot_q <= wr_data[cnv_pkg::MASK_W-1:0];
				cnv_pkg::REG_PAD_MODE: pad_mode_q <= wr_data[0];
				cnv_pkg::REG_WIDTH:    width_q    <= wr_data[cnv_pkg::WREG_W-1:0];
				cnv_pkg::REG_HEIGHT:   height_q   <= wr_data[cnv_pkg::HREG_W-1:0];
				default: ; // unknown index: drop the write
			endcase
		end
	end

	// a new frame size restarts the frame
	assign restart = wr_en && (wr_index == cnv_pkg::REG_WIDTH || wr_index == cnv_pkg::REG_HEIGHT);

	// clamp the frame size into the usable range
	always_comb begin
		if (width_q == '0)
			eff_w = cnv_pkg::WREG_W'(1);
		else if (width_q > cnv_pkg::WREG_W'(cnv_pkg::WMAX_INT))
			eff_w = cnv_pkg::WREG_W'(cnv_pkg::WMAX_INT);
		else
			eff_w = width_q;
		if (height_q == '0)
			eff_h = cnv_pkg::HREG_W'(1);
		else if (height_q > cnv_pkg::HREG_W'(cnv_pkg::MAX_HEIGHT))
			eff_h = cnv_pkg::HREG_W'(cnv_pkg::MAX_HEIGHT);
		else
			eff_h = height_q;
	end

	// ---------------------------------------------------------------- accept stage
	// Hold off input once the queue could not take every result in flight.
	assign in_stream.ready = pending_q < (cnv_pkg::FIFO_AW + 1)'(cnv_pkg::FIFO_DEPTH);
	assign acc      = in_stream.valid && in_stream.ready;
	assign is_pixel = in_row_q < eff_h;
	// a drain while pixels are still expected changes nothing
	assign drop     = is_pixel && in_stream.command;
	assign step     = acc && !drop;

	// a result is due once one row plus one pixel has gone in
	assign emit = (in_row_q >= cnv_pkg::HREG_W'(2)) ||
	              (in_row_q == cnv_pkg::HREG_W'(1) && in_col_q != '0);

	// border flags of the output pixel
	assign rv_top   = out_row_q != '0;
	assign rv_bot   = (cnv_pkg::HREG_W'(out_row_q) + cnv_pkg::HREG_W'(1)) < eff_h;
	assign cv_left  = out_col_q != '0;
	assign cv_right = out_col_inc < eff_w;
	assign last     = (cnv_pkg::HREG_W'(out_row_q) == eff_h - cnv_pkg::HREG_W'(1)) &&
	                  (cnv_pkg::WREG_W'(out_col_q) == eff_w - cnv_pkg::WREG_W'(1));

	assign in_col_inc  = cnv_pkg::WREG_W'(in_col_q) + cnv_pkg::WREG_W'(1);
	assign out_col_inc = cnv_pkg::WREG_W'(out_col_q) + cnv_pkg::WREG_W'(1);
	assign rd_addr     = cnv_pkg::ADDR_W'(in_col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (restart || (step && emit && last)) begin
			// end of frame: start over on the next pixel
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (step) begin
			if (in_col_inc >= eff_w) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + cnv_pkg::HREG_W'(1);
			end else begin
				in_col_q <= cnv_pkg::COL_W'(in_col_inc);
			end
			if (emit) begin
				if (out_col_inc >= eff_w) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + cnv_pkg::OROW_W'(1);
				end else begin
					out_col_q <= cnv_pkg::COL_W'(out_col_inc);
				end
			end
		end
	end

	// results accepted but not yet taken, in flight or queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({step && emit, pop})
				2'b10:   pending_q <= pending_q + (cnv_pkg::FIFO_AW + 1)'(1);
				2'b01:   pending_q <= pending_q - (cnv_pkg::FIFO_AW + 1)'(1);
				default: pending_q <= pending_q;
			endcase
		end
	end

	// ---------------------------------------------------------------- line stores
	// Read the column at accept and write it back in the next cycle.
	always_ff @(posedge clk) begin
		if (step) begin
			up_rd_q <= upper_mem[rd_addr];
			lo_rd_q <= lower_mem[rd_addr];
		end
		if (v_s1 && isp_s1) begin
			upper_mem[addr_s1] <= lo_now;
			lower_mem[addr_s1] <= pix_s1;
		end
	end

	// Forward the write of stage 1 when the next item reads the same column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= step && v_s1 && isp_s1 && (addr_s1 == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_up_q <= lo_now;
		fwd_lo_q <= pix_s1;
	end

	assign up_now = fwd_q ? fwd_up_q : up_rd_q;
	assign lo_now = fwd_q ? fwd_lo_q : lo_rd_q;

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			isp_s1      <= is_pixel;
			pix_s1      <= is_pixel ? in_stream.pixel_in : '0;
			addr_s1     <= rd_addr;
			emit_s1     <= emit;
			last_s1     <= last;
			rv_top_s1   <= rv_top;
			rv_bot_s1   <= rv_bot;
			cv_left_s1  <= cv_left;
			cv_right_s1 <= cv_right;
		end
	end

	// shift the window left and bring in the new column
	always_comb begin
		for (int r = 0; r < cnv_pkg::KDIM; r++) begin
			win_next[r * cnv_pkg::KDIM + 0] = win_q[r * cnv_pkg::KDIM + 1];
			win_next[r * cnv_pkg::KDIM + 1] = win_q[r * cnv_pkg::KDIM + 2];
		end
		win_next[2] = up_now;
		win_next[5] = lo_now;
		win_next[8] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) win_q[k] <= '0;
		end else if (restart) begin
			for (int k = 0; k < TAPS; k++) win_q[k] <= '0;
		end else if (v_s1) begin
			for (int k = 0; k < TAPS; k++) win_q[k] <= win_next[k];
		end
	end

	// Pad taps outside the frame: zero, or the nearest pixel inside in replicate mode.
	always_comb begin
		logic rv, cv;
		int   ri, cj;
		for (int i = 0; i < cnv_pkg::KDIM; i++) begin
			for (int j = 0; j < cnv_pkg::KDIM; j++) begin
				rv = (i == 0) ? rv_top_s1  : ((i == 2) ? rv_bot_s1   : 1'b1);
				cv = (j == 0) ? cv_left_s1 : ((j == 2) ? cv_right_s1 : 1'b1);
				ri = rv ? i : 1;
				cj = cv ? j : 1;
				tap_sel[i * cnv_pkg::KDIM + j] = ((rv && cv) || pad_mode_q) ?
					win_next[ri * cnv_pkg::KDIM + cj] : '0;
			end
		end
	end

	// ---------------------------------------------------------------- stages 2 to 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		for (int j = 0; j < cnv_pkg::KDIM; j++) begin
			coef_c[j]     = cnv_pkg::coef_at(mask_top_q, j);
			coef_c[3 + j] = cnv_pkg::coef_at(mask_mid_q, j);
			coef_c[6 + j] = cnv_pkg::coef_at(mask_bot_q, j);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < TAPS; k++) begin
			tap_s2[k]  <= tap_sel[k];
			prod_s3[k] <= cnv_pkg::PROD_W'($signed({1'b0, tap_s2[k]})) *
			              cnv_pkg::PROD_W'(coef_c[k]);
		end
		for (int r = 0; r < cnv_pkg::KDIM; r++) begin
			rsum_s4[r] <= cnv_pkg::SUM_W'(prod_s3[r * cnv_pkg::KDIM + 0]) +
			              cnv_pkg::SUM_W'(prod_s3[r * cnv_pkg::KDIM + 1]) +
			              cnv_pkg::SUM_W'(prod_s3[r * cnv_pkg::KDIM + 2]);
		end
		last_s2 <= last_s1;
		last_s3 <= last_s2;
		last_s4 <= last_s3;
	end

	// final sum and clamp into pixel range
	assign total = rsum_s4[0] + rsum_s4[1] + rsum_s4[2];

	always_comb begin
		if (total < 0)
			clamped = '0;
		else if (total > cnv_pkg::SUM_W'(cnv_pkg::PIX_MAX))
			clamped = PW'(cnv_pkg::PIX_MAX);
		else
			clamped = total[PW-1:0];
	end

	// ---------------------------------------------------------------- result queue
	assign push = v_s4;
	assign pop  = out_stream.valid && out_stream.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].pixel_out  <= clamped;
			fifo_q[wr_ptr_q].frame_last <= last_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + cnv_pkg::FIFO_AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + cnv_pkg::FIFO_AW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (cnv_pkg::FIFO_AW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (cnv_pkg::FIFO_AW + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign out_stream.valid      = cnt_q != '0;
	assign out_stream.pixel_out  = fifo_q[rd_ptr_q].pixel_out;
	assign out_stream.frame_last = fifo_q[rd_ptr_q].frame_last;

	// ---------------------------------------------------------------- assertions
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= (cnv_pkg::FIFO_AW + 1)'(cnv_pkg::FIFO_DEPTH))
		else $error("pending result count above queue depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q != (cnv_pkg::FIFO_AW + 1)'(cnv_pkg::FIFO_DEPTH))
		else $error("result pushed into full queue");

	a_queue_in_credit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pending_q)
		else $error("queued results exceed pending count");

	a_fwd_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> v_s1)
		else $error("line store forward without an item in stage 1");

	a_emit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit) |=> pending_q != '0)
		else $error("emitting item not counted as pending");

endmodule
